// File: sv/diff_drive_turn_to_point_defines.svh
// Assertion macros for the turn-to-point block
`ifndef DIFF_DRIVE_TURN_TO_POINT_DEFINES_SVH
`define DIFF_DRIVE_TURN_TO_POINT_DEFINES_SVH
`define DDTP_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define DDTP_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: sv/ddtp_pkg.sv
// ----------------------------------------------------------------------------
// ddtp_pkg
// Shared types and constants of the turn-to-point block.
// ----------------------------------------------------------------------------
package ddtp_pkg;
    localparam int CORDIC_STAGES = 16;
    localparam int CW = 28;
    localparam int DW = 18;
    localparam int SQ_STEPS = 17;

    typedef enum logic [1:0] {
        ACT_STOP     = 2'd0,
        ACT_STRAIGHT = 2'd1,
        ACT_TURN     = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        CFG_MAX_SPEED  = 2'd0,
        CFG_FIELD_DIAG = 2'd1,
        CFG_POINT_THR  = 2'd2,
        CFG_ANGLE_TOL  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  max_speed;
        logic [15:0] field_diag;
        logic [15:0] point_thresh;
        logic [14:0] angle_tolerance;
    } cfg_t;

    function automatic logic [15:0] atan_turn(input int i);
        case (i)
            0: return 16'd8192;  1: return 16'd4836;  2: return 16'd2555;
            3: return 16'd1297;  4: return 16'd651;   5: return 16'd326;
            6: return 16'd163;   7: return 16'd81;    8: return 16'd41;
            9: return 16'd20;    10: return 16'd10;   11: return 16'd5;
            12: return 16'd3;    13: return 16'd1;    14: return 16'd1;
            default: return 16'd0;
        endcase
    endfunction
endpackage

// File: sv/diff_drive_turn_to_point.sv
// ----------------------------------------------------------------------------
// diff_drive_turn_to_point
// Wheel command generator for a differential-drive robot heading to a point.
// ----------------------------------------------------------------------------
// Takes one transfer per cycle while the output is not stalled; each result passes
// through the set-up stage, the 17-step CORDIC/square-root pipeline, the error
// stage, the 9-step divider and the output register.
// The whole pipeline halts while a finished result is not taken.
module diff_drive_turn_to_point
    import ddtp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // robot_x, robot_y, robot_heading, target_x, target_y
    input  logic [79:0] s_tdata,
    // robot_id
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // left_speed, right_speed, pad
    output logic [23:0] m_tdata,
    // robot_out_id, action
    output logic [4:0]  m_tuser
);
    cfg_t cfg;
    logic en;
    logic gv;
    logic [2:0] gid;
    logic [15:0] gb, gh;
    logic [DW-1:0] gd;
    logic [8:0] l, r;
    action_t act;
    logic [2:0] oid;

    logic signed [16:0] dx, dy;
    assign dx = 17'(signed'(s_tdata[63:48])) - 17'(signed'(s_tdata[15:0]));
    assign dy = 17'(signed'(s_tdata[79:64])) - 17'(signed'(s_tdata[31:16]));

    assign en = !m_tvalid || m_tready;
    assign s_tready = en;

    ddtp_cfg u_cfg (.aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata, .cfg);

    ddtp_geom u_geom (
        .aclk, .aresetn, .en,
        .in_valid(s_tvalid), .in_id(s_tuser), .in_dx(dx), .in_dy(dy),
        .in_head(s_tdata[47:32]),
        .out_valid(gv), .out_id(gid), .out_bear(gb), .out_dist(gd),
        .out_head(gh)
    );

    ddtp_cmd u_cmd (
        .aclk, .aresetn, .en, .cfg,
        .in_valid(gv), .in_id(gid), .in_bear(gb), .in_dist(gd), .in_head(gh),
        .out_valid(m_tvalid), .out_id(oid), .out_left(l), .out_right(r),
        .out_action(act)
    );

    assign m_tdata = {6'd0, r, l};
    assign m_tuser = {act, oid};
endmodule

// File: sv/ddtp_cfg.sv
// ----------------------------------------------------------------------------
// ddtp_cfg
// Configuration register file.
// ----------------------------------------------------------------------------
module ddtp_cfg
    import ddtp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output cfg_t        cfg
);
    cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we && cfg_index[2] == 1'b0) begin
            unique case (cfg_idx_t'(cfg_index[1:0]))
                CFG_MAX_SPEED:  cfg_next.max_speed = cfg_wdata[7:0];
                CFG_FIELD_DIAG: cfg_next.field_diag = cfg_wdata;
                CFG_POINT_THR:  cfg_next.point_thresh = cfg_wdata;
                CFG_ANGLE_TOL:  cfg_next.angle_tolerance = cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{8'd100, 16'd4000, 16'd50, 15'd1043};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

// File: sv/ddtp_geom.sv
// ----------------------------------------------------------------------------
// ddtp_geom
// Pipelined CORDIC bearing and bit-pair square root, one stage per step.
// ----------------------------------------------------------------------------
module ddtp_geom
    import ddtp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2:0]        in_id,
    input  logic signed [16:0] in_dx,
    input  logic signed [16:0] in_dy,
    input  logic [15:0]       in_head,
    output logic              out_valid,
    output logic [2:0]        out_id,
    output logic [15:0]       out_bear,
    output logic [DW-1:0]     out_dist,
    output logic [15:0]       out_head
);
    localparam int N = (CORDIC_STAGES > SQ_STEPS) ? CORDIC_STAGES : SQ_STEPS;

    // stage 0: squares and CORDIC set-up
    logic              v0_reg;
    logic [2:0]        id0_reg;
    logic [15:0]       hd0_reg, an0_reg;
    logic signed [CW-1:0] x0_reg, y0_reg;
    logic              z0_reg;
    logic [35:0]       n0_reg;

    logic [16:0] ax, ay;
    assign ax = in_dx[16] ? 17'(-in_dx) : 17'(in_dx);
    assign ay = in_dy[16] ? 17'(-in_dy) : 17'(in_dy);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            id0_reg <= in_id;
            hd0_reg <= in_head;
            z0_reg  <= (in_dx == 17'sd0) && (in_dy == 17'sd0);
            an0_reg <= in_dx[16] ? 16'd32768 : 16'd0;
            x0_reg  <= in_dx[16] ? (-CW'(in_dx)) <<< 8 : CW'(in_dx) <<< 8;
            y0_reg  <= in_dx[16] ? (-CW'(in_dy)) <<< 8 : CW'(in_dy) <<< 8;
            n0_reg  <= 36'(ax * ax) + 36'(ay * ay);
        end
    end

    logic              v_reg [N];
    logic [2:0]        id_reg [N];
    logic [15:0]       hd_reg [N];
    logic [15:0]       an_reg [N];
    logic signed [CW-1:0] x_reg [N];
    logic signed [CW-1:0] y_reg [N];
    logic              z_reg [N];
    logic [35:0]       n_reg [N];
    logic [DW-1:0]     r_reg [N];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_st
            logic              pv, pz;
            logic [2:0]        pid;
            logic [15:0]       phd, pan;
            logic signed [CW-1:0] px, py;
            logic [35:0]       pn;
            logic [DW-1:0]     pr;
            logic [35:0]       trial, bitv;
            if (g == 0) begin : g_f
                assign pv = v0_reg; assign pz = z0_reg; assign pid = id0_reg;
                assign phd = hd0_reg; assign pan = an0_reg;
                assign px = x0_reg; assign py = y0_reg;
                assign pn = n0_reg; assign pr = '0;
            end else begin : g_n
                assign pv = v_reg[g-1]; assign pz = z_reg[g-1];
                assign pid = id_reg[g-1]; assign phd = hd_reg[g-1];
                assign pan = an_reg[g-1]; assign px = x_reg[g-1];
                assign py = y_reg[g-1]; assign pn = n_reg[g-1];
                assign pr = r_reg[g-1];
            end
            // remainder pn, root pr: test bit pair 2*(SQ_STEPS-1-g)
            assign bitv  = 36'd1 << (2 * (SQ_STEPS - 1 - g));
            assign trial = (36'(pr) << (2 * (SQ_STEPS - g))) + bitv;
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[g] <= 1'b0;
                end else if (en) begin
                    v_reg[g] <= pv;
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    id_reg[g] <= pid;
                    hd_reg[g] <= phd;
                    z_reg[g]  <= pz;
                    if (g < CORDIC_STAGES) begin
                        if (!py[CW-1]) begin
                            x_reg[g]  <= px + (py >>> g);
                            y_reg[g]  <= py - (px >>> g);
                            an_reg[g] <= pan + atan_turn(g);
                        end else begin
                            x_reg[g]  <= px - (py >>> g);
                            y_reg[g]  <= py + (px >>> g);
                            an_reg[g] <= pan - atan_turn(g);
                        end
                    end else begin
                        x_reg[g] <= px; y_reg[g] <= py; an_reg[g] <= pan;
                    end
                    if (g < SQ_STEPS) begin
                        if (pn >= trial) begin
                            n_reg[g] <= pn - trial;
                            r_reg[g] <= {pr[DW-2:0], 1'b1};
                        end else begin
                            n_reg[g] <= pn;
                            r_reg[g] <= {pr[DW-2:0], 1'b0};
                        end
                    end else begin
                        n_reg[g] <= pn; r_reg[g] <= pr;
                    end
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[N-1];
    assign out_id    = id_reg[N-1];
    assign out_head  = hd_reg[N-1];
    assign out_bear  = z_reg[N-1] ? 16'd0 : an_reg[N-1];
    assign out_dist  = r_reg[N-1];
endmodule

// File: sv/ddtp_cmd.sv
// ----------------------------------------------------------------------------
// ddtp_cmd
// Heading error, speed profile division and wheel command, pipelined.
// ----------------------------------------------------------------------------
module ddtp_cmd
    import ddtp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  cfg_t              cfg,
    input  logic              in_valid,
    input  logic [2:0]        in_id,
    input  logic [15:0]       in_bear,
    input  logic [DW-1:0]     in_dist,
    input  logic [15:0]       in_head,
    output logic              out_valid,
    output logic [2:0]        out_id,
    output logic [8:0]        out_left,
    output logic [8:0]        out_right,
    output action_t           out_action
);
    localparam int PW = 26;   // max_speed * dist
    localparam int QW = 9;    // quotient bits, result saturated to max_speed

    // stage A: error, fold, product
    logic              va_reg, rva_reg, ala_reg, nra_reg, za_reg;
    logic [2:0]        ida_reg;
    logic signed [16:0] era_reg;
    logic [PW-1:0]     pa_reg;

    logic signed [16:0] e0, e1;
    logic               rv;
    logic [16:0]        mag;
    always_comb begin
        e0 = 17'(signed'(16'(in_bear - in_head)));
        rv = 1'b0;
        e1 = e0;
        if (e0 > 17'sd16384) begin
            e1 = e0 - 17'sd32768; rv = 1'b1;
        end else if (e0 < -17'sd16384) begin
            e1 = e0 + 17'sd32768; rv = 1'b1;
        end
        mag = e1[16] ? 17'(-e1) : 17'(e1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            ida_reg <= in_id;
            era_reg <= e1;
            rva_reg <= rv;
            ala_reg <= mag < 17'(cfg.angle_tolerance);
            nra_reg <= 24'(in_dist) < 24'(cfg.point_thresh);
            za_reg  <= cfg.field_diag == 16'd0;
            pa_reg  <= PW'(cfg.max_speed) * PW'(in_dist);
        end
    end

    // restoring divide, one quotient bit per stage, saturated
    logic          vd_reg [QW];
    logic [2:0]    idd_reg [QW];
    logic signed [16:0] erd_reg [QW];
    logic          rvd_reg [QW], ald_reg [QW], nrd_reg [QW], zd_reg [QW];
    logic [PW-1:0] rm_reg [QW];
    logic [QW-1:0] q_reg [QW];
    logic          sat_reg [QW];

    genvar g;
    generate
        for (g = 0; g < QW; g++) begin : g_dv
            logic pv, prv, pal, pnr, pz, psat;
            logic [2:0] pid;
            logic signed [16:0] per;
            logic [PW-1:0] prm;
            logic [QW-1:0] pq;
            logic [PW+QW-1:0] sh;
            if (g == 0) begin : g_f
                assign pv = va_reg; assign pid = ida_reg; assign per = era_reg;
                assign prv = rva_reg; assign pal = ala_reg; assign pnr = nra_reg;
                assign pz = za_reg; assign prm = pa_reg; assign pq = '0;
                // quotient >= 2^QW saturates anyway
                assign psat = (pa_reg >> QW) >= PW'(cfg.field_diag);
            end else begin : g_n
                assign pv = vd_reg[g-1]; assign pid = idd_reg[g-1];
                assign per = erd_reg[g-1]; assign prv = rvd_reg[g-1];
                assign pal = ald_reg[g-1]; assign pnr = nrd_reg[g-1];
                assign pz = zd_reg[g-1]; assign prm = rm_reg[g-1];
                assign pq = q_reg[g-1]; assign psat = sat_reg[g-1];
            end
            assign sh = (PW+QW)'(cfg.field_diag) << (QW - 1 - g);
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vd_reg[g] <= 1'b0;
                end else if (en) begin
                    vd_reg[g] <= pv;
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    idd_reg[g] <= pid; erd_reg[g] <= per; rvd_reg[g] <= prv;
                    ald_reg[g] <= pal; nrd_reg[g] <= pnr; zd_reg[g] <= pz;
                    sat_reg[g] <= psat;
                    if ((PW+QW)'(prm) >= sh) begin
                        rm_reg[g] <= PW'((PW+QW)'(prm) - sh);
                        q_reg[g]  <= pq | (QW'(1) << (QW - 1 - g));
                    end else begin
                        rm_reg[g] <= prm;
                        q_reg[g]  <= pq;
                    end
                end
            end
        end
    endgenerate

    // final stage: command
    logic          vf_reg;
    logic [2:0]    idf_reg;
    logic [8:0]    lf_reg, rf_reg;
    action_t       af_reg;

    logic [8:0]  prof;
    logic signed [25:0] tp;
    logic signed [8:0]  tr;
    always_comb begin
        if (zd_reg[QW-1] || sat_reg[QW-1] ||
            q_reg[QW-1] > QW'(cfg.max_speed)) begin
            prof = {1'b0, cfg.max_speed};
        end else begin
            prof = q_reg[QW-1];
        end
        tp = -(26'(erd_reg[QW-1]) * 26'(signed'({1'b0, cfg.max_speed})));
        tr = 9'(tp >>> 19);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf_reg <= 1'b0;
        end else if (en) begin
            vf_reg <= vd_reg[QW-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            idf_reg <= idd_reg[QW-1];
            if (ald_reg[QW-1] && nrd_reg[QW-1]) begin
                lf_reg <= '0; rf_reg <= '0; af_reg <= ACT_STOP;
            end else if (ald_reg[QW-1]) begin
                lf_reg <= rvd_reg[QW-1] ? 9'(-prof) : prof;
                rf_reg <= rvd_reg[QW-1] ? 9'(-prof) : prof;
                af_reg <= ACT_STRAIGHT;
            end else begin
                rf_reg <= tr;
                lf_reg <= 9'(-tr);
                af_reg <= ACT_TURN;
            end
        end
    end

    assign out_valid  = vf_reg;
    assign out_id     = idf_reg;
    assign out_left   = lf_reg;
    assign out_right  = rf_reg;
    assign out_action = af_reg;
endmodule

// File: sv/ddtp_checker.sv
// ----------------------------------------------------------------------------
// ddtp_checker
// Port-level checks of the turn-to-point block.
// ----------------------------------------------------------------------------
`include "diff_drive_turn_to_point_defines.svh"
module ddtp_checker
    import ddtp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [4:0]  m_tuser
);
    `DDTP_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `DDTP_ASSERT_IMP(a_rdy, aclk, aresetn, 1'b1, s_tready == (!m_tvalid || m_tready))
    `DDTP_ASSERT_IMP(a_act, aclk, aresetn, m_tvalid, m_tuser[4:3] != 2'd3)
    `DDTP_ASSERT_IMP(a_stop, aclk, aresetn, m_tvalid && m_tuser[4:3] == ACT_STOP, m_tdata[17:0] == 18'd0)
endmodule

bind diff_drive_turn_to_point ddtp_checker u_chk (
    .aclk, .aresetn, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);

// File: bench/diff_drive_turn_to_point_tb.sv
// ----------------------------------------------------------------------------
// diff_drive_turn_to_point_tb
// Self-checking bench: directed and random robot/target transfers under
// several register settings, each result compared with a local prediction.
// ----------------------------------------------------------------------------
module diff_drive_turn_to_point_tb;
    import ddtp_pkg::*;

    typedef struct packed {
        logic [2:0] id;
        logic [8:0] left;
        logic [8:0] right;
        action_t    act;
    } wheel_cmd_t;

    localparam int SETTLE = 40;
    localparam int STALL_LIMIT = 5000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [4:0]  m_tuser;

    logic [7:0]  max_speed;
    logic [15:0] field_diag;
    logic [15:0] point_thresh;
    logic [14:0] angle_tol;

    wheel_cmd_t  pending_cmds[$];
    int          mismatches = 0;
    int          stall_cycles = 0;
    bit          calm = 1'b0;

    int unsigned turn_table[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                    41, 20, 10, 5, 3, 1, 1, 0};

    diff_drive_turn_to_point dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [15:0] bearing_of(longint dx, longint dy);
        longint x, y, nx;
        logic [15:0] ang;
        ang = 16'd0;
        if (dx == 0 && dy == 0) return 16'd0;
        if (dx < 0) begin
            dx = -dx;
            dy = -dy;
            ang = 16'd32768;
        end
        x = dx * 256;
        y = dy * 256;
        for (int i = 0; i < 16; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                ang = ang + turn_table[i][15:0];
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                ang = ang - turn_table[i][15:0];
            end
            x = nx;
        end
        return ang;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic wheel_cmd_t wheel_command(logic [2:0] id, logic [79:0] d);
        longint dx, dy, e, prof, left, right, mag;
        longint unsigned span;
        logic [15:0] diff;
        bit rev;
        wheel_cmd_t c;
        dx = longint'($signed(d[63:48])) - longint'($signed(d[15:0]));
        dy = longint'($signed(d[79:64])) - longint'($signed(d[31:16]));
        span = floor_sqrt(longint'(dx * dx + dy * dy));
        diff = bearing_of(dx, dy) - d[47:32];
        e = longint'($signed(diff));
        rev = 1'b0;
        if (e > 16384) begin
            e = e - 32768;
            rev = 1'b1;
        end else if (e < -16384) begin
            e = e + 32768;
            rev = 1'b1;
        end
        if (field_diag == 0) prof = max_speed;
        else begin
            prof = longint'((longint'(max_speed) * span) / field_diag);
            if (prof > max_speed) prof = max_speed;
        end
        mag = e < 0 ? -e : e;
        c.id = id;
        if (mag < angle_tol && span < point_thresh) begin
            left = 0;
            right = 0;
            c.act = ACT_STOP;
        end else if (mag < angle_tol) begin
            left = rev ? -prof : prof;
            right = left;
            c.act = ACT_STRAIGHT;
        end else begin
            right = (-(e * longint'(max_speed))) >>> 19;
            left = -right;
            c.act = ACT_TURN;
        end
        c.left = left[8:0];
        c.right = right[8:0];
        return c;
    endfunction

    always @(negedge aclk) m_tready <= calm || ($urandom_range(99) >= 17);

    always @(posedge aclk) begin
        wheel_cmd_t want, got;
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got.id = m_tuser[2:0];
            got.act = action_t'(m_tuser[4:3]);
            got.left = m_tdata[8:0];
            got.right = m_tdata[17:9];
            if (pending_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_cmds.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch exp %p got %p", want, got);
                end
            end
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("diff_drive_turn_to_point verification failed");
            $finish;
        end
    end

    task automatic send_item(logic [2:0] id, logic signed [15:0] rx, logic signed [15:0] ry,
                             logic [15:0] hd, logic signed [15:0] tx, logic signed [15:0] ty);
        if (!calm && $urandom_range(99) < 17) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= id;
        s_tdata <= {ty, tx, hd, ry, rx};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        pending_cmds.push_back(wheel_command(id, {ty, tx, hd, ry, rx}));
    endtask

    task automatic drain;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= {1'b0, idx};
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_SPEED:  max_speed = v[7:0];
            CFG_FIELD_DIAG: field_diag = v;
            CFG_POINT_THR:  point_thresh = v;
            CFG_ANGLE_TOL:  angle_tol = v[14:0];
        endcase
    endtask

    task automatic set_regs(logic [15:0] ms, logic [15:0] fd, logic [15:0] pt,
                            logic [15:0] at);
        write_reg(CFG_MAX_SPEED, ms);
        write_reg(CFG_FIELD_DIAG, fd);
        write_reg(CFG_POINT_THR, pt);
        write_reg(CFG_ANGLE_TOL, at);
    endtask

    // heading relative to the bearing: aim straight, reversed, or off by some
    task automatic aimed_item(logic [2:0] id, logic signed [15:0] rx, logic signed [15:0] ry,
                              logic signed [15:0] tx, logic signed [15:0] ty, int offs);
        logic [15:0] b;
        b = bearing_of(longint'(tx) - longint'(rx), longint'(ty) - longint'(ry));
        send_item(id, rx, ry, b - offs[15:0], tx, ty);
    endtask

    task automatic test_directed;
        send_item(3'd0, 16'sh8000, 16'sh8000, 16'h8000, 16'sh7fff, 16'sh7fff);
        send_item(3'd7, 16'sh7fff, 16'sh7fff, 16'h7fff, 16'sh8000, 16'sh8000);
        send_item(3'd1, 16'sh7fff, 16'sh8000, 16'h0000, 16'sh8000, 16'sh7fff);
        send_item(3'd2, 16'sd100, 16'sd100, 16'h1234, 16'sd100, 16'sd100);
        send_item(3'd3, 16'sd0, 16'sd0, 16'h0000, 16'sd0, 16'sd0);
        aimed_item(3'd4, 16'sd0, 16'sd0, 16'sd10, 16'sd10, 0);
        aimed_item(3'd5, 16'sd0, 16'sd0, 16'sd3000, 16'sd0, 0);
        aimed_item(3'd6, 16'sd0, 16'sd0, 16'sd3000, -16'sd2000, 32768);
        aimed_item(3'd1, 16'sd0, 16'sd0, 16'sd30000, 16'sd30000, 0);
        aimed_item(3'd2, 16'sd0, 16'sd0, -16'sd500, 16'sd700, 16384);
        aimed_item(3'd3, 16'sd0, 16'sd0, -16'sd500, 16'sd700, -16384);
        aimed_item(3'd4, 16'sd0, 16'sd0, 16'sd500, 16'sd700, 16385);
        aimed_item(3'd5, 16'sd0, 16'sd0, 16'sd500, 16'sd700, -16385);
        aimed_item(3'd6, 16'sd0, 16'sd0, 16'sd500, -16'sd700, 8000);
        aimed_item(3'd7, 16'sd0, 16'sd0, 16'sd500, -16'sd700, -8000);
        aimed_item(3'd0, 16'sd0, 16'sd0, 16'sd49, 16'sd0, 0);
        aimed_item(3'd0, 16'sd0, 16'sd0, 16'sd50, 16'sd0, 0);
        aimed_item(3'd1, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 0);
        aimed_item(3'd1, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 0);
        aimed_item(3'd2, 16'sd5, 16'sd5, 16'sd5, 16'sd900, 1042);
        aimed_item(3'd2, 16'sd5, 16'sd5, 16'sd5, 16'sd900, 1043);
    endtask

    task automatic test_random(int n);
        logic signed [15:0] rx, ry, tx, ty;
        int offs;
        bit raw;
        for (int k = 0; k < n; k++) begin
            calm = (k % 200) >= 150;
            if (k == n / 2) drain();
            rx = 16'($urandom);
            ry = 16'($urandom);
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    tx = rx + $signed(16'($urandom_range(600))) - 16'sd300;
                    ty = ry + $signed(16'($urandom_range(600))) - 16'sd300;
                end
                4: begin
                    tx = rx;
                    ty = ry;
                end
                default: begin
                    tx = 16'($urandom);
                    ty = 16'($urandom);
                end
            endcase
            raw = 1'b0;
            offs = 0;
            case ($urandom_range(5))
                0: raw = 1'b1;
                1: offs = 32768 + $signed($urandom_range(4000)) - 2000;
                2: offs = $signed($urandom_range(40000)) - 20000;
                default: offs = $signed($urandom_range(2 * angle_tol + 40)) - angle_tol - 20;
            endcase
            if (raw) send_item(3'($urandom), rx, ry, 16'($urandom), tx, ty);
            else aimed_item(3'($urandom), rx, ry, tx, ty, offs);
        end
        calm = 1'b0;
    endtask

    task automatic test_bad_index;
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= 3'd4 + 3'($urandom_range(3));
        cfg_wdata <= 16'hffff;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        max_speed = 8'd100;
        field_diag = 16'd4000;
        point_thresh = 16'd50;
        angle_tol = 15'd1043;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(300);
        drain();
        set_regs(16'd255, 16'd1, 16'd65535, 16'd16384);
        test_bad_index();
        test_directed();
        test_random(300);
        drain();
        set_regs(16'd0, 16'd0, 16'd0, 16'd0);
        test_random(250);
        drain();
        set_regs(16'd255, 16'd0, 16'd200, 16'd3000);
        test_random(300);
        drain();
        set_regs(16'd255, 16'd65535, 16'd10, 16'd500);
        test_random(300);
        drain();
        set_regs(16'($urandom_range(1, 255)), 16'($urandom_range(50, 3000)),
                 16'($urandom_range(0, 300)), 16'($urandom_range(100, 6000)));
        test_random(400);
        drain();
        if (mismatches == 0 && pending_cmds.size() == 0)
            $display("diff_drive_turn_to_point verification clean");
        else
            $display("diff_drive_turn_to_point verification failed");
        $finish;
    end
endmodule
